FILE: sv/bpf_pkg.sv
package bpf_pkg;

	localparam int QUAD_STEPS_DEF  = 16;
	localparam int CUBIC_STEPS_DEF = 20;

	localparam logic [2:0] CMD_MOVE  = 3'd0;
	localparam logic [2:0] CMD_LINE  = 3'd1;
	localparam logic [2:0] CMD_QUAD  = 3'd2;
	localparam logic [2:0] CMD_CUBIC = 3'd3;
	localparam logic [2:0] CMD_CLOSE = 3'd4;

	// shared multiply-accumulate unit operations
	localparam logic [1:0] UOP_HOLD = 2'd0;
	localparam logic [1:0] UOP_SET  = 2'd1;
	localparam logic [1:0] UOP_MAC  = 2'd2;
	localparam logic [1:0] UOP_MUL  = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic signed [15:0] ctrl1_x;
		logic signed [15:0] ctrl1_y;
		logic signed [15:0] ctrl2_x;
		logic signed [15:0] ctrl2_y;
	} path_cmd_t;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               last;
	} path_point_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] opa;
		logic [31:0] opb;
	} mu_req_t;

	// Bernstein weight of term k at step i of n, scaled by n^2 or n^3
	function automatic logic [15:0] bern_weight(input int n, input int i, input int k,
			input logic cubic);
		int a;
		int b;
		int w;
		a = n - i;
		b = i;
		w = 0;
		if (i <= n) begin
			if (cubic) begin
				if (k == 0)
					w = a * a * a;
				else if (k == 1)
					w = 3 * a * a * b;
				else if (k == 2)
					w = 3 * a * b * b;
				else
					w = b * b * b;
			end else begin
				if (k == 0)
					w = a * a;
				else if (k == 1)
					w = 2 * a * b;
				else if (k == 2)
					w = b * b;
				else
					w = 0;
			end
		end
		return 16'(w);
	endfunction

endpackage

FILE: sv/bezier_path_flattener_core.sv
// Path flattener: takes path commands on cmd_* and returns points on point_*.
// Both channels use valid/stall; a transaction completes on a clock edge with
// valid high and stall low. cmd_stall is high while a command is in work.
// Move and line return their endpoint, close returns the first point of the
// path (nothing before any point exists), codes 5 to 7 return nothing.
// Quadratic and cubic curves return QUAD_STEPS and CUBIC_STEPS points; the
// final point of every command carries last.
// A single-point command goes from idle to the put state and then into the
// output register, and the block is ready for a new command once the put is
// done. A curve point is built on one shared 32x32 multiply-accumulate unit:
// K products per coordinate (K = 3 quadratic, 4 cubic), one reciprocal
// multiply and one quotient pick, x then y, and then the put into the output.
// A stalled point holds in the output register and the sequencer waits for
// the slot to free before it goes on to the next point.
// Reset clears the pen, the first point and the point-seen flag to zero and
// leaves the block idle with no point pending.
module bezier_path_flattener_core #(
	parameter int QUAD_STEPS  = bpf_pkg::QUAD_STEPS_DEF,
	parameter int CUBIC_STEPS = bpf_pkg::CUBIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  bpf_pkg::path_cmd_t   cmd_data,
	output logic                 point_valid,
	input  logic                 point_stall,
	output bpf_pkg::path_point_t point_data
);

	localparam int MAX_STEPS = (QUAD_STEPS > CUBIC_STEPS) ? QUAD_STEPS : CUBIC_STEPS;
	localparam int PW        = $clog2(MAX_STEPS);

	localparam longint Q_DEN   = longint'(QUAD_STEPS) * QUAD_STEPS;
	localparam int     Q_SHIFT = 31 + $clog2(Q_DEN);
	localparam longint Q_RECIP = ((longint'(1) << Q_SHIFT) + Q_DEN - 1) / Q_DEN;
	localparam longint Q_HALF  = Q_DEN / 2;

	localparam longint C_DEN   = longint'(CUBIC_STEPS) * CUBIC_STEPS * CUBIC_STEPS;
	localparam int     C_SHIFT = 31 + $clog2(C_DEN);
	localparam longint C_RECIP = ((longint'(1) << C_SHIFT) + C_DEN - 1) / C_DEN;
	localparam longint C_HALF  = C_DEN / 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_RECIP = 3'd3;
	localparam logic [2:0] ST_QUO   = 3'd4;
	localparam logic [2:0] ST_PUT   = 3'd5;

	logic [2:0]           state_q;
	bpf_pkg::path_cmd_t   item_q;
	logic signed [15:0]   pen_x_q;
	logic signed [15:0]   pen_y_q;
	logic signed [15:0]   first_x_q;
	logic signed [15:0]   first_y_q;
	logic                 has_point_q;
	logic [PW-1:0]        pt_q;
	logic [1:0]           term_q;
	logic                 coord_q;
	logic signed [15:0]   px_q;
	logic signed [15:0]   res_x_q;
	logic signed [15:0]   res_y_q;
	logic                 res_last_q;
	bpf_pkg::path_point_t out_q;
	logic                 out_valid_q;

	logic [15:0]        qw [MAX_STEPS][4];
	logic [15:0]        cw [MAX_STEPS][4];
	logic               is_cubic;
	logic [1:0]         last_term;
	logic [PW-1:0]      last_pt;
	logic [15:0]        weight;
	logic signed [15:0] coord;
	logic [15:0]        coord_biased;
	logic [31:0]        half;
	logic [31:0]        recip;
	logic [15:0]        quo_biased;
	logic signed [15:0] quo;
	logic               out_free;
	bpf_pkg::mu_req_t   mu_req;
	logic [63:0]        acc;

	for (genvar g = 0; g < MAX_STEPS; g++) begin : g_step
		for (genvar k = 0; k < 4; k++) begin : g_term
			assign qw[g][k] = bpf_pkg::bern_weight(QUAD_STEPS, g + 1, k, 1'b0);
			assign cw[g][k] = bpf_pkg::bern_weight(CUBIC_STEPS, g + 1, k, 1'b1);
		end
	end

	assign is_cubic  = (item_q.command == bpf_pkg::CMD_CUBIC);
	assign last_term = is_cubic ? 2'd3 : 2'd2;
	assign last_pt   = is_cubic ? PW'(CUBIC_STEPS - 1) : PW'(QUAD_STEPS - 1);
	assign weight    = is_cubic ? cw[pt_q][term_q] : qw[pt_q][term_q];
	assign half      = is_cubic ? 32'(C_HALF) : 32'(Q_HALF);
	assign recip     = is_cubic ? 32'(C_RECIP) : 32'(Q_RECIP);

	always_comb begin
		unique case (term_q)
			2'd0: coord = coord_q ? pen_y_q : pen_x_q;
			2'd1: coord = coord_q ? item_q.ctrl1_y : item_q.ctrl1_x;
			2'd2: begin
				if (is_cubic)
					coord = coord_q ? item_q.ctrl2_y : item_q.ctrl2_x;
				else
					coord = coord_q ? item_q.end_y : item_q.end_x;
			end
			2'd3: coord = coord_q ? item_q.end_y : item_q.end_x;
		endcase
	end

	// offset by 32768 so the whole sum stays unsigned
	assign coord_biased = {~coord[15], coord[14:0]};

	assign quo_biased = is_cubic ? acc[C_SHIFT +: 16] : acc[Q_SHIFT +: 16];
	assign quo        = {~quo_biased[15], quo_biased[14:0]};

	always_comb begin
		mu_req.op  = bpf_pkg::UOP_HOLD;
		mu_req.opa = half;
		mu_req.opb = recip;
		unique case (state_q)
			ST_INIT: mu_req.op = bpf_pkg::UOP_SET;
			ST_MAC: begin
				mu_req.op  = bpf_pkg::UOP_MAC;
				mu_req.opa = 32'(weight);
				mu_req.opb = 32'(coord_biased);
			end
			ST_RECIP: begin
				mu_req.op  = bpf_pkg::UOP_MUL;
				mu_req.opa = acc[31:0];
			end
			ST_QUO: begin
				if (!coord_q)
					mu_req.op = bpf_pkg::UOP_SET;
			end
			default: mu_req.op = bpf_pkg::UOP_HOLD;
		endcase
	end

	bpf_mul_unit u_mul (
		.clk (clk),
		.req (mu_req),
		.acc (acc)
	);

	assign out_free = !out_valid_q || !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			has_point_q <= 1'b0;
			pt_q        <= '0;
			term_q      <= '0;
			coord_q     <= 1'b0;
			px_q        <= '0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_last_q  <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !point_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						item_q     <= cmd_data;
						pt_q       <= '0;
						res_last_q <= 1'b1;
						unique case (cmd_data.command)
							bpf_pkg::CMD_MOVE, bpf_pkg::CMD_LINE: begin
								res_x_q <= cmd_data.end_x;
								res_y_q <= cmd_data.end_y;
								state_q <= ST_PUT;
							end
							bpf_pkg::CMD_QUAD, bpf_pkg::CMD_CUBIC: state_q <= ST_INIT;
							bpf_pkg::CMD_CLOSE: begin
								res_x_q <= first_x_q;
								res_y_q <= first_y_q;
								if (has_point_q)
									state_q <= ST_PUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INIT: begin
					term_q  <= '0;
					coord_q <= 1'b0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					term_q <= term_q + 2'd1;
					if (term_q == last_term)
						state_q <= ST_RECIP;
				end
				ST_RECIP: state_q <= ST_QUO;
				ST_QUO: begin
					if (!coord_q) begin
						px_q    <= quo;
						coord_q <= 1'b1;
						term_q  <= '0;
						state_q <= ST_MAC;
					end else begin
						res_x_q    <= px_q;
						res_y_q    <= quo;
						res_last_q <= (pt_q == last_pt);
						state_q    <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						out_q.point_x <= res_x_q;
						out_q.point_y <= res_y_q;
						out_q.last    <= res_last_q;
						out_valid_q   <= 1'b1;
						if (!has_point_q) begin
							first_x_q   <= res_x_q;
							first_y_q   <= res_y_q;
							has_point_q <= 1'b1;
						end
						if (res_last_q) begin
							// close leaves the pen where it is
							if (item_q.command != bpf_pkg::CMD_CLOSE) begin
								pen_x_q <= item_q.end_x;
								pen_y_q <= item_q.end_y;
							end
							state_q <= ST_IDLE;
						end else begin
							pt_q    <= pt_q + PW'(1);
							state_q <= ST_INIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_stall   = (state_q != ST_IDLE);
	assign point_valid = out_valid_q;
	assign point_data  = out_q;

`ifndef SYNTHESIS
	a_busy_mid_command: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall && !point_data.last) |-> cmd_stall)
		else $error("command transaction possible before its last point");

	a_point_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		has_point_q |=> has_point_q)
		else $error("point-seen flag cleared outside reset");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && is_cubic) |-> (int'(pt_q) < CUBIC_STEPS))
		else $error("cubic step index beyond step count");

	a_put_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && point_stall) |=> point_valid)
		else $error("pending point dropped while stalled");
`endif

endmodule

FILE: sv/bpf_mul_unit.sv
module bpf_mul_unit (
	input  logic             clk,
	input  bpf_pkg::mu_req_t req,
	output logic [63:0]      acc
);

	logic [63:0] prod;
	logic [63:0] acc_q;

	assign prod = 64'(req.opa) * 64'(req.opb);

	always_ff @(posedge clk) begin
		unique case (req.op)
			bpf_pkg::UOP_HOLD: acc_q <= acc_q;
			bpf_pkg::UOP_SET:  acc_q <= 64'(req.opa);
			bpf_pkg::UOP_MAC:  acc_q <= acc_q + prod;
			bpf_pkg::UOP_MUL:  acc_q <= prod;
		endcase
	end

	assign acc = acc_q;

endmodule

FILE: bench/bezier_path_flattener_core_test.sv
`timescale 1ns / 100ps

module bezier_path_flattener_core_test;

	localparam int QUAD_N      = bpf_pkg::QUAD_STEPS_DEF;
	localparam int CUBIC_N     = bpf_pkg::CUBIC_STEPS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 400;
	localparam int REPORT_MAX  = 10;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	bpf_pkg::path_cmd_t   cmd_data;
	logic                 point_valid;
	logic                 point_stall = 1'b0;
	bpf_pkg::path_point_t point_data;

	bezier_path_flattener_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_data (point_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic signed [15:0] pos_x, pos_y;
	logic signed [15:0] origin_x, origin_y;
	logic               origin_set;

	bpf_pkg::path_point_t expected_points[$];
	bpf_pkg::path_point_t want_point;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	int cmd_count     = 0;
	int curve_count   = 0;
	int point_count   = 0;

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("%s", msg);
	endfunction

	// floor((num + den/2) / den), saturated to 16 bits
	function automatic logic signed [15:0] round_nearest(longint num, longint den);
		longint n;
		longint q;
		n = num + den / 2;
		if (n >= 0)
			q = n / den;
		else
			q = -((-n + den - 1) / den);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic void push_point(logic signed [15:0] x, logic signed [15:0] y,
			logic fin);
		bpf_pkg::path_point_t p;
		p.point_x = x;
		p.point_y = y;
		p.last    = fin;
		if (!origin_set) begin
			origin_x   = x;
			origin_y   = y;
			origin_set = 1'b1;
		end
		expected_points = {expected_points, p};
	endfunction

	function automatic void predict_points(bpf_pkg::path_cmd_t c);
		longint wt[4];
		longint cx[4];
		longint cy[4];
		longint den;
		longint a;
		longint b;
		longint sx;
		longint sy;
		int     steps;
		logic   cubic;
		case (c.command)
			bpf_pkg::CMD_MOVE, bpf_pkg::CMD_LINE: begin
				push_point(c.end_x, c.end_y, 1'b1);
				pos_x = c.end_x;
				pos_y = c.end_y;
			end
			bpf_pkg::CMD_QUAD, bpf_pkg::CMD_CUBIC: begin
				cubic = (c.command == bpf_pkg::CMD_CUBIC);
				steps = cubic ? CUBIC_N : QUAD_N;
				den   = cubic ? longint'(steps) * steps * steps : longint'(steps) * steps;
				cx[0] = pos_x;
				cy[0] = pos_y;
				cx[1] = c.ctrl1_x;
				cy[1] = c.ctrl1_y;
				cx[2] = cubic ? longint'(c.ctrl2_x) : longint'(c.end_x);
				cy[2] = cubic ? longint'(c.ctrl2_y) : longint'(c.end_y);
				cx[3] = c.end_x;
				cy[3] = c.end_y;
				for (int i = 1; i <= steps; i++) begin
					a = steps - i;
					b = i;
					if (cubic) begin
						wt[0] = a * a * a;
						wt[1] = 3 * a * a * b;
						wt[2] = 3 * a * b * b;
						wt[3] = b * b * b;
					end else begin
						wt[0] = a * a;
						wt[1] = 2 * a * b;
						wt[2] = b * b;
						wt[3] = 0;
					end
					sx = 0;
					sy = 0;
					for (int k = 0; k < 4; k++) begin
						sx += wt[k] * cx[k];
						sy += wt[k] * cy[k];
					end
					push_point(round_nearest(sx, den), round_nearest(sy, den), i == steps);
				end
				pos_x = c.end_x;
				pos_y = c.end_y;
			end
			bpf_pkg::CMD_CLOSE: begin
				if (origin_set)
					push_point(origin_x, origin_y, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_coord();
		logic signed [15:0] v;
		case ($urandom_range(3))
			0: v = 16'($urandom);
			1: begin
				case ($urandom_range(3))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = 16'sh0000;
					default: v = -16'sd1;
				endcase
			end
			default: v = 16'(int'($urandom_range(4095)) - 2048);
		endcase
		return v;
	endfunction

	function automatic bpf_pkg::path_cmd_t make_cmd(logic [2:0] op,
			logic signed [15:0] ex, logic signed [15:0] ey,
			logic signed [15:0] c1x, logic signed [15:0] c1y,
			logic signed [15:0] c2x, logic signed [15:0] c2y);
		bpf_pkg::path_cmd_t c;
		c.command = op;
		c.end_x   = ex;
		c.end_y   = ey;
		c.ctrl1_x = c1x;
		c.ctrl1_y = c1y;
		c.ctrl2_x = c2x;
		c.ctrl2_y = c2y;
		return c;
	endfunction

	function automatic bpf_pkg::path_cmd_t random_cmd(logic [2:0] op);
		return make_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord());
	endfunction

	// Called and returns at a falling edge; valid stays high for a back-to-back send.
	task automatic send_cmd(input bpf_pkg::path_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		predict_points(c);
		if (c.command <= bpf_pkg::CMD_CLOSE)
			cmd_count++;
		if (c.command == bpf_pkg::CMD_QUAD || c.command == bpf_pkg::CMD_CUBIC)
			curve_count++;
		@(negedge clk);
	endtask

	// Hold off the sender until every pending point has come out.
	task automatic wait_for_points();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (expected_points.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_path();
		send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
		send_cmd(random_cmd(3'd5));
		send_cmd(random_cmd(3'd6));
		send_cmd(random_cmd(3'd7));
	endtask

	// Curve with no prior move starts from the origin and sets the first point.
	task automatic test_curve_from_reset();
		send_cmd(make_cmd(bpf_pkg::CMD_QUAD, 16'sd800, 16'sd480, 16'sd1600, -16'sd3200,
			16'sh7fff, 16'sh8000));
		send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
	endtask

	task automatic test_move_line_close();
		send_cmd(make_cmd(bpf_pkg::CMD_MOVE, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff));
		send_cmd(make_cmd(bpf_pkg::CMD_LINE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000));
		send_cmd(make_cmd(bpf_pkg::CMD_MOVE, 16'sd0, 16'sd0, rand_coord(), rand_coord(),
			rand_coord(), rand_coord()));
		send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
		send_cmd(make_cmd(bpf_pkg::CMD_LINE, -16'sd1, 16'sd0, rand_coord(), rand_coord(),
			rand_coord(), rand_coord()));
		send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
	endtask

	task automatic test_curve_extremes();
		send_cmd(make_cmd(bpf_pkg::CMD_MOVE, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0,
			16'sd0, 16'sd0));
		send_cmd(make_cmd(bpf_pkg::CMD_CUBIC, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh7fff));
		send_cmd(make_cmd(bpf_pkg::CMD_QUAD, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			rand_coord(), rand_coord()));
		send_cmd(make_cmd(bpf_pkg::CMD_CUBIC, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
			16'sd0, 16'sd0));
		// small coordinates of both signs exercise rounding near halves
		send_cmd(make_cmd(bpf_pkg::CMD_QUAD, -16'sd3, 16'sd2, 16'sd1, -16'sd1, 16'sh7fff,
			16'sh8000));
		send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
	endtask

	task automatic test_random_paths(input int target, input int send_pct, input int recv_pct);
		int                 sent;
		int                 pick;
		bpf_pkg::path_cmd_t c;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(99) < 15) begin
				// noise: unknown code, stray close, or a curve with no move before it
				pick = $urandom_range(2);
				if (pick == 0)
					c = random_cmd(3'($urandom_range(5, 7)));
				else if (pick == 1)
					c = random_cmd(bpf_pkg::CMD_CLOSE);
				else
					c = random_cmd($urandom_range(1) ? bpf_pkg::CMD_QUAD :
						bpf_pkg::CMD_CUBIC);
				send_cmd(c);
				if (c.command <= bpf_pkg::CMD_CLOSE)
					sent++;
			end else begin
				send_cmd(random_cmd(bpf_pkg::CMD_MOVE));
				sent++;
				repeat ($urandom_range(1, 5)) begin
					pick = $urandom_range(2);
					send_cmd(random_cmd(pick == 0 ? bpf_pkg::CMD_LINE :
						pick == 1 ? bpf_pkg::CMD_QUAD : bpf_pkg::CMD_CUBIC));
					sent++;
				end
				if ($urandom_range(99) < 60) begin
					send_cmd(random_cmd(bpf_pkg::CMD_CLOSE));
					sent++;
				end
			end
		end
	endtask

	task automatic finish_run();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (expected_points.size() != 0)
			note_failure($sformatf("%0d expected points never arrived",
				expected_points.size()));
		$display("Sent %0d path commands (%0d curves) and checked %0d points,",
			cmd_count, curve_count, point_count);
		$display("under sender-heavy, receiver-heavy and free-running flow control.");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	endtask

	always @(negedge clk)
		point_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && point_valid && !point_stall) begin
			point_count++;
			if (expected_points.size() == 0) begin
				note_failure($sformatf("unexpected point x=%0d y=%0d last=%0b",
					point_data.point_x, point_data.point_y, point_data.last));
			end else begin
				want_point = expected_points.pop_front();
				if (point_data.point_x !== want_point.point_x ||
						point_data.point_y !== want_point.point_y ||
						point_data.last !== want_point.last)
					note_failure($sformatf(
						"point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
						want_point.point_x, want_point.point_y, want_point.last,
						point_data.point_x, point_data.point_y, point_data.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd_data    = '0;
		pos_x       = '0;
		pos_y       = '0;
		origin_x    = '0;
		origin_y    = '0;
		origin_set  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 64;
		test_empty_path();
		test_curve_from_reset();
		test_move_line_close();
		test_curve_extremes();
		wait_for_points();

		test_random_paths(50, 10, 64);
		wait_for_points();
		test_random_paths(50, 64, 10);
		test_random_paths(50, 0, 0);
		finish_run();
	end

endmodule
